FILE: hdl/otr_pkg.sv
// Package for the overwriting trace ring: ring size, command codes and the
// entry and queue-operation types shared by the front, the queue and the back.
// No dependencies.
`default_nettype none

package otr_pkg;

    // Ring size. The slot is taken from the low bits of a position, so this must be
    // a power of two between 2 and 4096.
    localparam int RING_ENTRIES = 64;
    localparam int SLOT_W       = $clog2(RING_ENTRIES);

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_UNWIND = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Distance from the oldest kept position to the current depth when full.
    localparam logic [31:0] RING_SPAN = 32'(RING_ENTRIES - 1);
    localparam logic [31:0] RING_SIZE = 32'(RING_ENTRIES);

    typedef struct packed {
        logic [31:0] frame_mark;
        logic [63:0] function_ref;
        logic [63:0] variable_ref;
        logic [63:0] type_label_ref;
        logic [63:0] value_address;
        logic [3:0]  value_kind;
        logic [15:0] value_bytes;
    } entry_t;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        logic              is_write;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        entry_t            data;
        logic [31:0]       depth;
        logic [31:0]       lost;
    } op_t;

endpackage

`default_nettype wire

FILE: hdl/otr_front.sv
// Front of the trace ring: accepts commands, keeps the depth and loss counters and
// turns each transaction into a ring operation for the back. Depends on otr_pkg.
`default_nettype none

module otr_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic [1:0]           command,
    input  wire logic [31:0]          frame_mark,
    input  wire logic [63:0]          function_ref,
    input  wire logic [63:0]          variable_ref,
    input  wire logic [63:0]          type_label_ref,
    input  wire logic [63:0]          value_address,
    input  wire logic [3:0]           value_kind,
    input  wire logic [15:0]          value_bytes,
    input  wire logic [31:0]          read_index,
    output otr_pkg::op_t              op
);

    logic [31:0] depth_reg, depth_next;
    logic [31:0] lost_reg, lost_next;
    logic [31:0] first_kept_pos;
    logic [31:0] live_now;
    logic [31:0] read_pos;

    always_comb begin
        first_kept_pos = depth_reg - otr_pkg::RING_SPAN;
        live_now       = depth_reg - lost_reg;
        read_pos       = lost_reg + read_index;

        depth_next = depth_reg;
        lost_next  = lost_reg;

        op.is_write            = 1'b0;
        op.hit                 = 1'b0;
        op.slot                = read_pos[otr_pkg::SLOT_W-1:0];
        op.data.frame_mark     = frame_mark;
        op.data.function_ref   = function_ref;
        op.data.variable_ref   = variable_ref;
        op.data.type_label_ref = type_label_ref;
        op.data.value_address  = value_address;
        op.data.value_kind     = value_kind;
        op.data.value_bytes    = value_bytes;

        unique case (command)
            otr_pkg::CMD_RECORD: begin
                // A full ring overwrites its oldest entry, which then counts as lost.
                if (depth_reg >= otr_pkg::RING_SIZE && first_kept_pos > lost_reg) begin
                    lost_next = first_kept_pos;
                end
                depth_next  = depth_reg + 32'd1;
                op.is_write = 1'b1;
                op.slot     = depth_reg[otr_pkg::SLOT_W-1:0];
            end
            otr_pkg::CMD_UNWIND: begin
                if (frame_mark < depth_reg) begin
                    depth_next = frame_mark;
                    if (lost_reg > frame_mark) begin
                        lost_next = frame_mark;
                    end
                end
            end
            otr_pkg::CMD_READ: begin
                op.hit = read_index < live_now;
            end
            default: begin
            end
        endcase

        op.depth = depth_next;
        op.lost  = lost_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            lost_reg  <= '0;
        end else if (accept) begin
            depth_reg <= depth_next;
            lost_reg  <= lost_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/otr_queue.sv
// Two-entry queue of ring operations between the front and the back.
// Depends on otr_pkg.
`default_nettype none

module otr_queue (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire otr_pkg::op_t push_op,
    output logic        full,
    input  wire logic   pop,
    output otr_pkg::op_t pop_op,
    output logic        empty
);

    otr_pkg::op_t slots_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full   = count_reg == 2'd2;
    assign empty  = count_reg == 2'd0;
    assign pop_op = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/otr_back.sv
// Back of the trace ring: holds the entry memory, carries out writes and reads and
// drives the output register of the result channel. Depends on otr_pkg.
`default_nettype none

module otr_back (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   empty,
    input  wire otr_pkg::op_t op,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic        out_hit,
    output otr_pkg::entry_t out_entry,
    output logic [31:0] out_depth,
    output logic [31:0] out_live,
    output logic [31:0] out_lost
);

    otr_pkg::entry_t ring_mem [otr_pkg::RING_ENTRIES];
    otr_pkg::entry_t rdata_reg;
    logic            valid_reg;
    logic            hit_reg;
    logic [31:0]     depth_reg;
    logic [31:0]     live_reg;
    logic [31:0]     lost_reg;

    assign pop       = !empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;
    assign out_entry = hit_reg ? rdata_reg : '0;
    assign out_depth = depth_reg;
    assign out_live  = live_reg;
    assign out_lost  = lost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // The read data register only moves when a new operation is taken, so a stalled
    // result keeps its entry fields.
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (op.is_write) begin
                ring_mem[op.slot] <= op.data;
            end
            rdata_reg <= ring_mem[op.slot];
            hit_reg   <= op.hit;
            depth_reg <= op.depth;
            live_reg  <= op.depth - op.lost;
            lost_reg  <= op.lost;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/overwriting_trace_ring_with_unwind_top.sv
// Top level of the overwriting trace ring: front, operation queue and back.
// Depends on otr_pkg, otr_front, otr_queue and otr_back.
//
//  Channel | Ports      | Direction | Contents
//  --------+------------+-----------+--------------------------------------------
//  input   | s_*        | in        | command, frame mark, entry fields, read index
//  result  | m_*        | out       | hit, entry fields, depth, live and dropped count
//
// One transaction is accepted per cycle while the two-entry queue has room. Its result
// is presented on m_valid once the back has popped it from the queue, read the entry
// memory and loaded its output registers; a stalled result channel can hold it back.
// Sustained rate is one per cycle while the result channel stays ready.
// Synchronous reset clears the counters and the queue; the entry memory is not cleared.
// A stalled result channel fills the queue and then holds s_ready low.
`default_nettype none

module overwriting_trace_ring_with_unwind_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_frame_mark,
    input  wire logic [63:0] s_function_ref,
    input  wire logic [63:0] s_variable_ref,
    input  wire logic [63:0] s_type_label_ref,
    input  wire logic [63:0] s_value_address,
    input  wire logic [3:0]  s_value_kind,
    input  wire logic [15:0] s_value_bytes,
    input  wire logic [31:0] s_read_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_entry_hit,
    output logic [31:0]      m_out_frame_mark,
    output logic [63:0]      m_out_function_ref,
    output logic [63:0]      m_out_variable_ref,
    output logic [63:0]      m_out_type_label_ref,
    output logic [63:0]      m_out_value_address,
    output logic [3:0]       m_out_value_kind,
    output logic [15:0]      m_out_value_bytes,
    output logic [31:0]      m_current_depth,
    output logic [31:0]      m_live_count,
    output logic [31:0]      m_dropped_count
);

    otr_pkg::op_t    front_op;
    otr_pkg::op_t    back_op;
    otr_pkg::entry_t out_entry;
    logic            accept;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    otr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .command        (s_command),
        .frame_mark     (s_frame_mark),
        .function_ref   (s_function_ref),
        .variable_ref   (s_variable_ref),
        .type_label_ref (s_type_label_ref),
        .value_address  (s_value_address),
        .value_kind     (s_value_kind),
        .value_bytes    (s_value_bytes),
        .read_index     (s_read_index),
        .op             (front_op)
    );

    otr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .push_op (front_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (back_op),
        .empty   (q_empty)
    );

    otr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (q_empty),
        .op        (back_op),
        .pop       (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_hit   (m_entry_hit),
        .out_entry (out_entry),
        .out_depth (m_current_depth),
        .out_live  (m_live_count),
        .out_lost  (m_dropped_count)
    );

    assign m_out_frame_mark     = out_entry.frame_mark;
    assign m_out_function_ref   = out_entry.function_ref;
    assign m_out_variable_ref   = out_entry.variable_ref;
    assign m_out_type_label_ref = out_entry.type_label_ref;
    assign m_out_value_address  = out_entry.value_address;
    assign m_out_value_kind     = out_entry.value_kind;
    assign m_out_value_bytes    = out_entry.value_bytes;

endmodule

`default_nettype wire

FILE: hdl/otr_checker.sv
// Port-level checks for the overwriting trace ring, bound to the top level.
// Depends on overwriting_trace_ring_with_unwind_top.
`default_nettype none

module otr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_entry_hit,
    input wire logic [31:0] m_out_frame_mark,
    input wire logic [3:0]  m_out_value_kind,
    input wire logic [15:0] m_out_value_bytes,
    input wire logic [31:0] m_current_depth,
    input wire logic [31:0] m_live_count,
    input wire logic [31:0] m_dropped_count
);

    // A stalled result transaction keeps its counters.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_depth)
            && $stable(m_dropped_count))
        else $error("stalled result changed");

    // The live count always agrees with depth minus dropped entries.
    a_live_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_live_count == m_current_depth - m_dropped_count)
        else $error("live count inconsistent");

    // A result without a hit carries cleared entry fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_entry_hit |-> m_out_frame_mark == 32'd0
            && m_out_value_kind == 4'd0 && m_out_value_bytes == 16'd0)
        else $error("miss result carries entry data");

    // A hit can only come from a ring with live entries.
    a_hit_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_entry_hit |-> m_live_count != 32'd0)
        else $error("hit on an empty ring");

    // Without any accepted input there is nothing new to report after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not quiet after reset");

endmodule

bind overwriting_trace_ring_with_unwind_top otr_checker u_otr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_entry_hit       (m_entry_hit),
    .m_out_frame_mark  (m_out_frame_mark),
    .m_out_value_kind  (m_out_value_kind),
    .m_out_value_bytes (m_out_value_bytes),
    .m_current_depth   (m_current_depth),
    .m_live_count      (m_live_count),
    .m_dropped_count   (m_dropped_count)
);

`default_nettype wire

FILE: test/trace_ring_checker.sv
// Checker for the overwriting trace ring: watches both channels, predicts each result
// from the accepted transactions and compares it field by field.
// Depends on otr_pkg for the ring size, command codes and entry type.

module trace_ring_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_frame_mark,
    input  wire logic [63:0] s_function_ref,
    input  wire logic [63:0] s_variable_ref,
    input  wire logic [63:0] s_type_label_ref,
    input  wire logic [63:0] s_value_address,
    input  wire logic [3:0]  s_value_kind,
    input  wire logic [15:0] s_value_bytes,
    input  wire logic [31:0] s_read_index,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_entry_hit,
    input  wire logic [31:0] m_out_frame_mark,
    input  wire logic [63:0] m_out_function_ref,
    input  wire logic [63:0] m_out_variable_ref,
    input  wire logic [63:0] m_out_type_label_ref,
    input  wire logic [63:0] m_out_value_address,
    input  wire logic [3:0]  m_out_value_kind,
    input  wire logic [15:0] m_out_value_bytes,
    input  wire logic [31:0] m_current_depth,
    input  wire logic [31:0] m_live_count,
    input  wire logic [31:0] m_dropped_count,
    output int               error_count = 0,
    output int               results_owed = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            hit;
        otr_pkg::entry_t entry;
        logic [31:0]     depth;
        logic [31:0]     live;
        logic [31:0]     dropped;
    } ring_report_t;

    otr_pkg::entry_t trace_store [otr_pkg::RING_ENTRIES];
    logic [31:0]     ring_level = '0;
    logic [31:0]     ring_lost  = '0;
    ring_report_t    owed_reports [$];
    int              results_seen = 0;

    // Applies one transaction to the shadow ring and returns the report it must produce.
    function automatic ring_report_t step_trace_ring(input logic [1:0] cmd,
                                                     input otr_pkg::entry_t e,
                                                     input logic [31:0] idx);
        ring_report_t r;
        logic [31:0]  pos;
        r = '0;
        case (cmd)
            otr_pkg::CMD_RECORD: begin
                // A full ring gives up its oldest entry before the slot is reused.
                if (ring_level >= otr_pkg::RING_SIZE
                        && ring_level - otr_pkg::RING_SPAN > ring_lost)
                    ring_lost = ring_level - otr_pkg::RING_SPAN;
                trace_store[ring_level % otr_pkg::RING_ENTRIES] = e;
                ring_level = ring_level + 32'd1;
            end
            otr_pkg::CMD_UNWIND: begin
                if (e.frame_mark < ring_level) begin
                    ring_level = e.frame_mark;
                    if (ring_lost > ring_level)
                        ring_lost = ring_level;
                end
            end
            otr_pkg::CMD_READ: begin
                if (idx < ring_level - ring_lost) begin
                    pos     = ring_lost + idx;
                    r.hit   = 1'b1;
                    r.entry = trace_store[pos % otr_pkg::RING_ENTRIES];
                end
            end
            default: ;
        endcase
        r.depth   = ring_level;
        r.live    = ring_level - ring_lost;
        r.dropped = ring_lost;
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t trace_ring_checker: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %h, want %h",
                                   results_seen, name, got, want));
    endtask

    always @(posedge aclk) begin : watch
        ring_report_t    seen;
        ring_report_t    want;
        otr_pkg::entry_t e;
        if (!aresetn) begin
            owed_reports.delete();
            ring_level = '0;
            ring_lost  = '0;
        end else begin
            // Results are retired before new transactions are queued, so a stray result
            // can never be matched against a transaction taken at the same edge.
            if (m_valid && m_ready) begin
                seen = {m_entry_hit, m_out_frame_mark, m_out_function_ref, m_out_variable_ref,
                        m_out_type_label_ref, m_out_value_address, m_out_value_kind,
                        m_out_value_bytes, m_current_depth, m_live_count, m_dropped_count};
                if (owed_reports.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no transaction owed",
                                           results_seen));
                end else begin
                    want = owed_reports.pop_front();
                    cmp_field("entry hit", 64'(seen.hit), 64'(want.hit));
                    cmp_field("frame mark", 64'(seen.entry.frame_mark),
                              64'(want.entry.frame_mark));
                    cmp_field("function ref", seen.entry.function_ref,
                              want.entry.function_ref);
                    cmp_field("variable ref", seen.entry.variable_ref,
                              want.entry.variable_ref);
                    cmp_field("type label ref", seen.entry.type_label_ref,
                              want.entry.type_label_ref);
                    cmp_field("value address", seen.entry.value_address,
                              want.entry.value_address);
                    cmp_field("value kind", 64'(seen.entry.value_kind),
                              64'(want.entry.value_kind));
                    cmp_field("value bytes", 64'(seen.entry.value_bytes),
                              64'(want.entry.value_bytes));
                    cmp_field("current depth", 64'(seen.depth), 64'(want.depth));
                    cmp_field("live count", 64'(seen.live), 64'(want.live));
                    cmp_field("dropped count", 64'(seen.dropped), 64'(want.dropped));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                e = {s_frame_mark, s_function_ref, s_variable_ref, s_type_label_ref,
                     s_value_address, s_value_kind, s_value_bytes};
                owed_reports.push_back(step_trace_ring(s_command, e, s_read_index));
            end
        end
        results_owed <= owed_reports.size();
    end

endmodule

FILE: test/tb_overwriting_trace_ring_with_unwind_top.sv
// Testbench top for the overwriting trace ring: clock, reset, stimulus and verdict.
// Depends on otr_pkg, overwriting_trace_ring_with_unwind_top and trace_ring_checker.

module tb_overwriting_trace_ring_with_unwind_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code the block leaves unused; it must only report the counters.
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command        = '0;
    logic [31:0] s_frame_mark     = '0;
    logic [63:0] s_function_ref   = '0;
    logic [63:0] s_variable_ref   = '0;
    logic [63:0] s_type_label_ref = '0;
    logic [63:0] s_value_address  = '0;
    logic [3:0]  s_value_kind     = '0;
    logic [15:0] s_value_bytes    = '0;
    logic [31:0] s_read_index     = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_entry_hit;
    logic [31:0] m_out_frame_mark;
    logic [63:0] m_out_function_ref;
    logic [63:0] m_out_variable_ref;
    logic [63:0] m_out_type_label_ref;
    logic [63:0] m_out_value_address;
    logic [3:0]  m_out_value_kind;
    logic [15:0] m_out_value_bytes;
    logic [31:0] m_current_depth;
    logic [31:0] m_live_count;
    logic [31:0] m_dropped_count;
    int          error_count;
    int          results_owed;

    int          send_idle_pct = 32;
    int          recv_idle_pct = 67;
    int          idle_cycles   = 0;

    // Depth and dropped count as seen by the stimulus, used only to aim reads and unwinds.
    logic [31:0] ring_level = '0;
    logic [31:0] ring_lost  = '0;

    overwriting_trace_ring_with_unwind_top dut (.*);

    trace_ring_checker checker_0 (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_overwriting_trace_ring_with_unwind_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic otr_pkg::entry_t random_entry();
        otr_pkg::entry_t e;
        e.frame_mark     = $urandom;
        e.function_ref   = {$urandom, $urandom};
        e.variable_ref   = {$urandom, $urandom};
        e.type_label_ref = {$urandom, $urandom};
        e.value_address  = {$urandom, $urandom};
        e.value_kind     = 4'($urandom_range(0, 8));
        e.value_bytes    = 16'($urandom);
        return e;
    endfunction

    // Presents one transaction, holds it until s_ready is seen high, then follows the counters.
    task automatic send_txn(input logic [1:0] cmd, input otr_pkg::entry_t e,
                            input logic [31:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_frame_mark     <= e.frame_mark;
        s_function_ref   <= e.function_ref;
        s_variable_ref   <= e.variable_ref;
        s_type_label_ref <= e.type_label_ref;
        s_value_address  <= e.value_address;
        s_value_kind     <= e.value_kind;
        s_value_bytes    <= e.value_bytes;
        s_read_index     <= idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (cmd == otr_pkg::CMD_RECORD) begin
            if (ring_level >= otr_pkg::RING_SIZE
                    && ring_level - otr_pkg::RING_SPAN > ring_lost)
                ring_lost = ring_level - otr_pkg::RING_SPAN;
            ring_level = ring_level + 32'd1;
        end else if (cmd == otr_pkg::CMD_UNWIND && e.frame_mark < ring_level) begin
            ring_level = e.frame_mark;
            if (ring_lost > ring_level)
                ring_lost = ring_level;
        end
    endtask

    task automatic send_random_txn();
        otr_pkg::entry_t e;
        logic [1:0]      cmd;
        logic [31:0]     idx;
        logic [31:0]     live;
        int              pick;
        e    = random_entry();
        idx  = $urandom;
        live = ring_level - ring_lost;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            cmd = otr_pkg::CMD_RECORD;
        end else if (pick < 80) begin
            cmd  = otr_pkg::CMD_READ;
            pick = $urandom_range(0, 9);
            if (pick < 6 && live != 0)
                idx = $urandom_range(0, live - 1);
            else if (pick < 8)
                idx = live;
            else if (pick < 9)
                idx = live + $urandom_range(1, 70);
        end else if (pick < 94) begin
            cmd  = otr_pkg::CMD_UNWIND;
            pick = $urandom_range(0, 19);
            // A fully random mark is almost always at or above the depth and is ignored.
            if (ring_level == 0 || pick < 6)
                ;
            else if (pick < 16 && ring_lost != 0)
                e.frame_mark = ring_lost - $urandom_range(0, ring_lost < 8 ? ring_lost : 8);
            else if (pick < 16)
                e.frame_mark = ring_level - $urandom_range(1, ring_level < 6 ? ring_level : 6);
            else
                e.frame_mark = ring_level;
        end else begin
            cmd = CMD_SPARE;
        end
        send_txn(cmd, e, idx);
    endtask

    initial begin
        otr_pkg::entry_t e;
        otr_pkg::entry_t ones;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        ones            = '1;
        ones.value_kind = 4'd8;
        send_txn(otr_pkg::CMD_READ, random_entry(), 32'd0);
        e            = random_entry();
        e.frame_mark = '0;
        send_txn(otr_pkg::CMD_UNWIND, e, $urandom);
        send_txn(CMD_SPARE, random_entry(), 32'd0);
        send_txn(otr_pkg::CMD_RECORD, ones, '1);
        send_txn(otr_pkg::CMD_RECORD, '0, '0);
        e            = random_entry();
        e.value_kind = 4'd7;
        send_txn(otr_pkg::CMD_RECORD, e, 32'd0);
        for (int i = 0; i < 4; i++)
            send_txn(otr_pkg::CMD_READ, random_entry(), 32'(i));
        send_txn(otr_pkg::CMD_READ, random_entry(), '1);
        e            = random_entry();
        e.frame_mark = 32'd3;
        send_txn(otr_pkg::CMD_UNWIND, e, 32'd0);
        e.frame_mark = 32'd1;
        send_txn(otr_pkg::CMD_UNWIND, e, 32'd0);
        send_txn(otr_pkg::CMD_READ, random_entry(), 32'd0);
        send_txn(otr_pkg::CMD_READ, random_entry(), 32'd1);
        send_txn(otr_pkg::CMD_RECORD, random_entry(), $urandom);
        e            = random_entry();
        e.frame_mark = '1;
        send_txn(otr_pkg::CMD_UNWIND, e, 32'd0);
        send_txn(CMD_SPARE, ones, '1);

        repeat (150) send_random_txn();
        send_idle_pct = 67;
        recv_idle_pct = 32;
        repeat (150) send_random_txn();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150) send_random_txn();

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (error_count == 0)
            $display("tb_overwriting_trace_ring_with_unwind_top: clean");
        else
            $display("tb_overwriting_trace_ring_with_unwind_top: errors");
        $finish;
    end

endmodule
